[src/assert_macros.svh]
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define RCM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rcm check failed");

// next-cycle implication, disabled while reset is asserted
`define RCM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rcm check failed");

`endif

[src/rcm_pkg.sv]
`default_nettype none

package rcm_pkg;

	// field and datapath widths
	localparam int SAMPLE_W  = 10;
	localparam int COUNT_W   = 15;
	localparam int SUM_W     = 35;
	localparam int MEAN_W    = 20;
	localparam int ROOT_W    = 10;
	localparam int ROOT_IDX_W = 4;
	localparam int SQREM_W   = 12;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int PROD_W    = CFG_W + ROOT_W;
	localparam int STEP_W    = 5;

	// window limit
	localparam int MAX_SAMPLES = 16384;

	// iteration counts of the serial units
	localparam int SQUARE_STEPS = SAMPLE_W;
	localparam int DIV_STEPS    = MEAN_W;
	localparam int SQRT_STEPS   = ROOT_W;
	localparam int SCALE_STEPS  = ROOT_W;

	// reset values
	localparam logic [CFG_W-1:0]    SCALE_RESET = 16'd6764;
	localparam logic [CFG_W-1:0]    LOW_RESET   = 16'd400;
	localparam logic [CFG_W-1:0]    HIGH_RESET  = 16'd3000;
	localparam logic [SAMPLE_W-1:0] ZERO_RESET  = 10'd512;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SCALE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH  = 2'd2;

	// window kinds
	localparam logic KIND_CAL  = 1'b0;
	localparam logic KIND_MEAS = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OFF    = 2'd0,
		STATUS_UNDER  = 2'd1,
		STATUS_OVER   = 2'd2,
		STATUS_NORMAL = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_DIV_INIT,
		ST_DIV,
		ST_SQRT,
		ST_SCALE,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

[src/rms_current_monitor_unit.sv]
// RMS current monitor. Samples arrive on the input channel grouped into windows closed by
// last; calibration windows (action 0) average the raw samples into the zero level, and
// measurement windows (action 1) give the floor square root of the floored mean squared
// offset, the current in mA (Q8 scale, saturating at 65535) and a status. Each window
// yields one request on the output channel, held in an output register. A calibration
// sample is accumulated as it is taken, while a measurement sample is squared by the
// bit-serial shift-add squarer (10 steps). At window end a 20-step restoring divider forms
// the mean, then for a measurement a 10-step digit square root and a 10-step serial scale
// multiplier run before the result is registered. One item is in work at a time; samples
// beyond 16384 in a window are counted out. Configuration is written through cfg_we.
`default_nettype none

module rms_current_monitor_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [rcm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rcm_pkg::CFG_W-1:0]      cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           action,
	input  wire logic [rcm_pkg::SAMPLE_W-1:0]   sample,
	input  wire logic                           last,
	input  wire logic                           pump_on,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic                                kind,
	output logic [rcm_pkg::SAMPLE_W-1:0]        zero_out,
	output logic [rcm_pkg::ROOT_W-1:0]          rms_counts,
	output logic [rcm_pkg::CFG_W-1:0]           current_ma,
	output logic [1:0]                          status,
	output logic [rcm_pkg::COUNT_W-1:0]         window_samples
);

	rcm_pkg::state_t state_q, state_d;
	logic [rcm_pkg::STEP_W-1:0]   step_q;

	logic [rcm_pkg::CFG_W-1:0]    scale_q, low_q, high_q;
	logic [rcm_pkg::SAMPLE_W-1:0] zero_q;
	logic [rcm_pkg::SUM_W-1:0]    sum_q;
	logic [rcm_pkg::COUNT_W-1:0]  count_q;

	logic                         action_q, last_q, pump_q;
	logic [rcm_pkg::MEAN_W-1:0]   mcand_q;
	logic [rcm_pkg::SAMPLE_W-1:0] mbits_q;
	logic [rcm_pkg::COUNT_W-1:0]  rem_q;
	logic [rcm_pkg::MEAN_W-1:0]   div_q;
	logic [rcm_pkg::SQREM_W-1:0]  sq_rem_q;
	logic [rcm_pkg::ROOT_W-1:0]   root_q;
	logic [rcm_pkg::PROD_W-1:0]   mul_q;

	logic                         out_valid_q, kind_q;
	logic [rcm_pkg::SAMPLE_W-1:0] zero_out_q;
	logic [rcm_pkg::ROOT_W-1:0]   rms_q;
	logic [rcm_pkg::CFG_W-1:0]    cur_q;
	rcm_pkg::status_t             status_q;
	logic [rcm_pkg::COUNT_W-1:0]  win_q;

	logic                         accept, room, out_write, step_last;
	logic [rcm_pkg::SAMPLE_W-1:0] offset;
	logic [rcm_pkg::COUNT_W:0]    div_trial;
	logic                         div_ge;
	logic [rcm_pkg::SQREM_W+1:0]  sq_trial, sq_sub;
	logic                         sq_ge;
	logic [rcm_pkg::ROOT_IDX_W-1:0] mul_idx;
	logic                         mul_bit;
	logic [rcm_pkg::CFG_W-1:0]    cur_val;
	rcm_pkg::status_t             status_val;

	// request handshake and window bookkeeping
	assign accept = in_valid && !in_stall;
	assign room   = count_q < rcm_pkg::COUNT_W'(rcm_pkg::MAX_SAMPLES);
	assign offset = (zero_q >= sample) ? (zero_q - sample) : (sample - zero_q);

	// restoring divider step: remainder against sample count
	assign div_trial = {rem_q, div_q[rcm_pkg::MEAN_W-1]};
	assign div_ge    = (count_q != '0) && (div_trial >= {1'b0, count_q});

	// digit square root step: two bits of the mean per cycle
	assign sq_trial = {sq_rem_q, div_q[rcm_pkg::MEAN_W-1 -: 2]};
	assign sq_sub   = {2'b00, root_q, 2'b01};
	assign sq_ge    = sq_trial >= sq_sub;

	// serial scale multiply, root bits msb first
	assign mul_idx = rcm_pkg::ROOT_IDX_W'(rcm_pkg::ROOT_W - 1) - step_q[rcm_pkg::ROOT_IDX_W-1:0];
	assign mul_bit = root_q[mul_idx];

	// saturate current and classify
	assign cur_val = (mul_q[rcm_pkg::PROD_W-1 -: 2] != 2'b00) ? '1
		: mul_q[rcm_pkg::CFG_W+7:8];

	always_comb begin
		if (!pump_q) begin
			status_val = rcm_pkg::STATUS_OFF;
		end else if (cur_val < low_q) begin
			status_val = rcm_pkg::STATUS_UNDER;
		end else if (cur_val > high_q) begin
			status_val = rcm_pkg::STATUS_OVER;
		end else begin
			status_val = rcm_pkg::STATUS_NORMAL;
		end
	end

	// end of the current serial phase
	always_comb begin
		unique case (state_q)
			rcm_pkg::ST_SQUARE:
				step_last = step_q == rcm_pkg::STEP_W'(rcm_pkg::SQUARE_STEPS - 1);
			rcm_pkg::ST_DIV:
				step_last = step_q == rcm_pkg::STEP_W'(rcm_pkg::DIV_STEPS - 1);
			rcm_pkg::ST_SQRT:
				step_last = step_q == rcm_pkg::STEP_W'(rcm_pkg::SQRT_STEPS - 1);
			rcm_pkg::ST_SCALE:
				step_last = step_q == rcm_pkg::STEP_W'(rcm_pkg::SCALE_STEPS - 1);
			default:
				step_last = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rcm_pkg::ST_IDLE: begin
				if (accept) begin
					if (action == rcm_pkg::KIND_MEAS && room) begin
						state_d = rcm_pkg::ST_SQUARE;
					end else if (last) begin
						state_d = rcm_pkg::ST_DIV_INIT;
					end
				end
			end
			rcm_pkg::ST_SQUARE: begin
				if (step_last) begin
					state_d = last_q ? rcm_pkg::ST_DIV_INIT : rcm_pkg::ST_IDLE;
				end
			end
			rcm_pkg::ST_DIV_INIT: begin
				state_d = rcm_pkg::ST_DIV;
			end
			rcm_pkg::ST_DIV: begin
				if (step_last) begin
					state_d = (action_q == rcm_pkg::KIND_MEAS) ? rcm_pkg::ST_SQRT
						: rcm_pkg::ST_DONE;
				end
			end
			rcm_pkg::ST_SQRT: begin
				if (step_last) begin
					state_d = rcm_pkg::ST_SCALE;
				end
			end
			rcm_pkg::ST_SCALE: begin
				if (step_last) begin
					state_d = rcm_pkg::ST_DONE;
				end
			end
			rcm_pkg::ST_DONE: begin
				if (out_write) begin
					state_d = rcm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rcm_pkg::ST_IDLE;
			end
		endcase
	end

	// handshake outputs of the sequencer
	always_comb begin
		in_stall  = state_q != rcm_pkg::ST_IDLE;
		out_write = (state_q == rcm_pkg::ST_DONE) && (!out_valid_q || !out_stall);
	end

	// control state, registers and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rcm_pkg::ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
			scale_q     <= rcm_pkg::SCALE_RESET;
			low_q       <= rcm_pkg::LOW_RESET;
			high_q      <= rcm_pkg::HIGH_RESET;
			zero_q      <= rcm_pkg::ZERO_RESET;
			sum_q       <= '0;
			count_q     <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= (state_d != state_q) ? '0 : step_q + 1'b1;

			// configuration writes
			if (cfg_we) begin
				unique case (cfg_index)
					rcm_pkg::REG_SCALE: scale_q <= cfg_data;
					rcm_pkg::REG_LOW:   low_q   <= cfg_data;
					rcm_pkg::REG_HIGH:  high_q  <= cfg_data;
					default: ;
				endcase
			end

			// output register valid
			if (out_write) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			// accumulate raw sample or squared offset
			if (accept && room) begin
				count_q <= count_q + 1'b1;
				if (action == rcm_pkg::KIND_CAL) begin
					sum_q <= sum_q + rcm_pkg::SUM_W'(sample);
				end
			end
			if (state_q == rcm_pkg::ST_SQUARE && mbits_q[0]) begin
				sum_q <= sum_q + rcm_pkg::SUM_W'(mcand_q);
			end

			// close the window
			if (out_write) begin
				if (action_q == rcm_pkg::KIND_CAL) begin
					zero_q <= div_q[rcm_pkg::SAMPLE_W-1:0];
				end
				sum_q   <= '0;
				count_q <= '0;
			end
		end
	end

	// serial datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			rcm_pkg::ST_IDLE: begin
				if (accept) begin
					action_q <= action;
					last_q   <= last;
					pump_q   <= pump_on;
					mcand_q  <= rcm_pkg::MEAN_W'(offset);
					mbits_q  <= offset;
				end
			end
			rcm_pkg::ST_SQUARE: begin
				mcand_q <= {mcand_q[rcm_pkg::MEAN_W-2:0], 1'b0};
				mbits_q <= {1'b0, mbits_q[rcm_pkg::SAMPLE_W-1:1]};
			end
			rcm_pkg::ST_DIV_INIT: begin
				rem_q    <= sum_q[rcm_pkg::SUM_W-1:rcm_pkg::MEAN_W];
				div_q    <= sum_q[rcm_pkg::MEAN_W-1:0];
				sq_rem_q <= '0;
				root_q   <= '0;
				mul_q    <= '0;
			end
			rcm_pkg::ST_DIV: begin
				rem_q <= div_ge ? rcm_pkg::COUNT_W'(div_trial - {1'b0, count_q})
					: div_trial[rcm_pkg::COUNT_W-1:0];
				div_q <= {div_q[rcm_pkg::MEAN_W-2:0], div_ge};
			end
			rcm_pkg::ST_SQRT: begin
				div_q <= {div_q[rcm_pkg::MEAN_W-3:0], 2'b00};
				if (sq_ge) begin
					sq_rem_q <= rcm_pkg::SQREM_W'(sq_trial - sq_sub);
					root_q   <= {root_q[rcm_pkg::ROOT_W-2:0], 1'b1};
				end else begin
					sq_rem_q <= sq_trial[rcm_pkg::SQREM_W-1:0];
					root_q   <= {root_q[rcm_pkg::ROOT_W-2:0], 1'b0};
				end
			end
			rcm_pkg::ST_SCALE: begin
				mul_q <= {mul_q[rcm_pkg::PROD_W-2:0], 1'b0}
					+ (mul_bit ? rcm_pkg::PROD_W'(scale_q) : '0);
			end
			default: ;
		endcase

		// result capture
		if (out_write) begin
			kind_q <= action_q;
			win_q  <= count_q;
			if (action_q == rcm_pkg::KIND_CAL) begin
				zero_out_q <= div_q[rcm_pkg::SAMPLE_W-1:0];
				rms_q      <= '0;
				cur_q      <= '0;
				status_q   <= rcm_pkg::STATUS_OFF;
			end else begin
				zero_out_q <= zero_q;
				rms_q      <= root_q;
				cur_q      <= cur_val;
				status_q   <= status_val;
			end
		end
	end

	// result ports
	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign zero_out       = zero_out_q;
	assign rms_counts     = rms_q;
	assign current_ma     = cur_q;
	assign status         = status_q;
	assign window_samples = win_q;

endmodule

`default_nettype wire

[src/rcm_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module rcm_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_valid,
	input wire logic                         in_stall,
	input wire logic                         last,
	input wire logic                         out_valid,
	input wire logic                         out_stall,
	input wire logic                         kind,
	input wire logic [rcm_pkg::SAMPLE_W-1:0] zero_out,
	input wire logic [rcm_pkg::ROOT_W-1:0]   rms_counts,
	input wire logic [rcm_pkg::CFG_W-1:0]    current_ma,
	input wire logic [1:0]                   status,
	input wire logic [rcm_pkg::COUNT_W-1:0]  window_samples
);

	// a stalled result request holds
	`RCM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(current_ma) && $stable(zero_out) && $stable(window_samples))

	// a calibration result carries no measurement
	`RCM_ASSERT_NOW(a_cal_clear, out_valid && kind == rcm_pkg::KIND_CAL, rms_counts == '0 && current_ma == '0 && status == rcm_pkg::STATUS_OFF)

	// an empty measurement window reads as zero current
	`RCM_ASSERT_NOW(a_empty_zero, out_valid && kind == rcm_pkg::KIND_MEAS && window_samples == '0, rms_counts == '0 && current_ma == '0)

	// closing a window starts the end-of-window sequence
	`RCM_ASSERT_NEXT(a_last_busy, in_valid && !in_stall && last, in_stall)

endmodule

bind rms_current_monitor_unit rcm_checker u_rcm_checker (.*);

`default_nettype wire
